/* rtl/sorted_priority_list_defines.svh */
// Assertion macros for the sorted priority list
`ifndef SORTED_PRIORITY_LIST_DEFINES_SVH
`define SORTED_PRIORITY_LIST_DEFINES_SVH

`ifndef SYNTH

// check that an expression holds at every edge out of reset
`define SPL_ASSERT_HOLDS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sorted priority list: invariant broken");

// check that a condition leads to a consequence on the next edge
`define SPL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sorted priority list: sequence broken");

`else

`define SPL_ASSERT_HOLDS(lbl, clk, rst, expr)
`define SPL_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/spl_pkg.sv */
package spl_pkg;

   localparam int unsigned CMD_BITS    = 2;
   localparam int unsigned STATUS_BITS = 2;
   localparam int unsigned COUNT_OUT_BITS = 5;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT   = 2'd0,
      CMD_POP_HEAD = 2'd1,
      CMD_POP_TAIL = 2'd2,
      CMD_REMOVE   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // one-cycle update orders broadcast to every cell
   typedef struct packed {
      logic insert;
      logic close_gap;
      logic pop_head;
   } cell_ctrl_type;

endpackage

/* rtl/spl_cell.sv */
module spl_cell
   import spl_pkg::*;
#(
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned COUNT_BITS = 5,
   parameter int unsigned IDX        = 0
) (
   input  logic                         clock,
   input  cell_ctrl_type                ctrl,
   input  logic signed [VALUE_BITS-1:0] key,
   input  logic        [COUNT_BITS-1:0] count,
   input  logic                         prev_gt,
   input  logic signed [VALUE_BITS-1:0] prev_value,
   input  logic signed [VALUE_BITS-1:0] next_value,
   output logic signed [VALUE_BITS-1:0] value,
   output logic                         gt,
   output logic                         hit,
   output logic                         tail
);

   localparam logic [COUNT_BITS-1:0] MY_IDX  = COUNT_BITS'(IDX);
   localparam logic [COUNT_BITS-1:0] MY_NEXT = COUNT_BITS'(IDX + 1);

   logic signed [VALUE_BITS-1:0] value_ff;
   logic signed [VALUE_BITS-1:0] value_in;
   logic                         occupied;

   assign occupied = count > MY_IDX;
   assign gt       = occupied && (value_ff > key);
   assign hit      = occupied && !gt && prev_gt && (value_ff == key);
   assign tail     = count == MY_NEXT;
   assign value    = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.insert && !gt) begin
         value_in = prev_gt ? key : prev_value;
      end else if (ctrl.close_gap && !gt) begin
         value_in = next_value;
      end else if (ctrl.pop_head) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

/* rtl/sorted_priority_list.sv */
// Channel  Dir  Handshake             tuser     tdata (lowest bit up)
// req      in   req_tvalid/tready     cmd       value
// rsp      out  rsp_tvalid/tready     status    removed_value, entry_count
//
// One command per cycle; its result appears in the output register in the cycle
// after acceptance. All cells update in that same cycle from their neighbours.
// req_tready is high whenever the output register is empty or being drained.
// Synchronous reset empties the list; cell contents are not cleared.
// A stalled result holds the output register and blocks further commands.
`include "sorted_priority_list_defines.svh"

module sorted_priority_list
   import spl_pkg::*;
#(
   parameter int unsigned DEPTH      = 16,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // cmd [1:0]
   input  logic [CMD_BITS-1:0]  req_tuser,
   // value [VALUE_BITS-1:0], zero padding above
   input  logic [((VALUE_BITS+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // status [1:0]
   output logic [STATUS_BITS-1:0] rsp_tuser,
   // removed_value [VALUE_BITS-1:0], entry_count [VALUE_BITS+4:VALUE_BITS], zero padding
   output logic [((VALUE_BITS+COUNT_OUT_BITS+7)/8)*8-1:0] rsp_tdata
);

   localparam int unsigned COUNT_BITS = $clog2(DEPTH + 1);
   localparam int unsigned RSP_BITS   = ((VALUE_BITS + COUNT_OUT_BITS + 7) / 8) * 8;
   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(DEPTH);
   localparam logic [COUNT_BITS-1:0] ONE        = COUNT_BITS'(1);

   logic                         accept;
   cmd_type                      cmd;
   logic signed [VALUE_BITS-1:0] key;
   logic                         full;
   logic                         empty;
   logic                         found;
   cell_ctrl_type                ctrl;

   logic signed [VALUE_BITS-1:0] cell_value [DEPTH];
   logic        [DEPTH-1:0]      cell_gt;
   logic        [DEPTH-1:0]      cell_hit;
   logic        [DEPTH-1:0]      cell_tail;
   logic signed [VALUE_BITS-1:0] tail_value;

   logic [COUNT_BITS-1:0]        count_ff;
   logic [COUNT_BITS-1:0]        count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   status_type                   status_ff;
   status_type                   status_in;
   logic signed [VALUE_BITS-1:0] removed_ff;
   logic signed [VALUE_BITS-1:0] removed_in;
   logic [COUNT_BITS-1:0]        rsp_count_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign key        = req_tdata[VALUE_BITS-1:0];
   assign full       = count_ff == FULL_COUNT;
   assign empty      = count_ff == '0;
   assign found      = |cell_hit;

   always_comb begin
      ctrl.insert    = accept && (cmd == CMD_INSERT) && !full;
      ctrl.close_gap = accept && (cmd == CMD_REMOVE) && found;
      ctrl.pop_head  = accept && (cmd == CMD_POP_HEAD) && !empty;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                         prev_gt;
      logic signed [VALUE_BITS-1:0] prev_value;
      logic signed [VALUE_BITS-1:0] next_value;

      if (i == 0) begin : g_head
         assign prev_gt    = 1'b1;
         assign prev_value = key;
      end else begin : g_body
         assign prev_gt    = cell_gt[i-1];
         assign prev_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_value = cell_value[i];
      end else begin : g_inner
         assign next_value = cell_value[i+1];
      end

      spl_cell #(
         .VALUE_BITS (VALUE_BITS),
         .COUNT_BITS (COUNT_BITS),
         .IDX        (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .key        (key),
         .count      (count_ff),
         .prev_gt    (prev_gt),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[i]),
         .gt         (cell_gt[i]),
         .hit        (cell_hit[i]),
         .tail       (cell_tail[i])
      );
   end

   always_comb begin
      tail_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_value = tail_value | (cell_tail[i] ? cell_value[i] : '0);
      end
   end

   always_comb begin
      status_in  = ST_OK;
      removed_in = '0;
      count_in   = count_ff;
      case (cmd)
         CMD_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + ONE;
            end
         end
         CMD_POP_HEAD: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               removed_in = cell_value[0];
               count_in   = count_ff - ONE;
            end
         end
         CMD_POP_TAIL: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               removed_in = tail_value;
               count_in   = count_ff - ONE;
            end
         end
         CMD_REMOVE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else if (found) begin
               removed_in = key;
               count_in   = count_ff - ONE;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         removed_ff   <= removed_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = RSP_BITS'({COUNT_OUT_BITS'(rsp_count_ff), removed_ff});

   `SPL_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= FULL_COUNT)
   `SPL_ASSERT_NEXT(a_insert_grows, clock, reset, ctrl.insert, count_ff == $past(count_ff) + ONE)
   `SPL_ASSERT_HOLDS(a_empty_result, clock, reset, !(rsp_valid_ff && status_ff == ST_EMPTY) || (removed_ff == '0 && rsp_count_ff == '0))
   `SPL_ASSERT_NEXT(a_full_result, clock, reset, accept && cmd == CMD_INSERT && full, status_ff == ST_FULL && rsp_count_ff == FULL_COUNT)

endmodule

/* tb/tb_sorted_priority_list.sv */
module tb_sorted_priority_list;
   import spl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DEPTH      = 16;
   localparam int unsigned VALUE_BITS = 32;
   localparam int unsigned REQ_BITS   = ((VALUE_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_BITS   = ((VALUE_BITS + COUNT_OUT_BITS + 7) / 8) * 8;
   localparam int unsigned RANDOM_WORDS = 1500;
   localparam int unsigned STALL_LIMIT  = 1000;
   localparam logic signed [VALUE_BITS-1:0] VAL_MAX = 32'sh7fffffff;
   localparam logic signed [VALUE_BITS-1:0] VAL_MIN = 32'sh80000000;

   class list_scoreboard;
      typedef struct {
         status_type             status;
         logic [VALUE_BITS-1:0]  removed;
         logic [COUNT_OUT_BITS-1:0] count;
      } reply_type;

      logic signed [VALUE_BITS-1:0] held[DEPTH];
      int unsigned fill;
      reply_type   awaited[$];
      int unsigned errors;

      function new();
         fill   = 0;
         errors = 0;
      endfunction

      function logic signed [VALUE_BITS-1:0] take_at(int unsigned pos);
         logic signed [VALUE_BITS-1:0] v;
         int unsigned i;
         v = held[pos];
         for (i = pos; i + 1 < fill; i++) held[i] = held[i + 1];
         fill--;
         return v;
      endfunction

      function void note_command(cmd_type c, logic signed [VALUE_BITS-1:0] v);
         reply_type r;
         int unsigned i, pos;
         bit hit;
         r.status  = ST_OK;
         r.removed = '0;
         if (c == CMD_INSERT) begin
            if (fill >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               pos = 0;
               while (pos < fill && held[pos] > v) pos++;
               for (i = fill; i > pos; i--) held[i] = held[i - 1];
               held[pos] = v;
               fill++;
            end
         end else if (fill == 0) begin
            r.status = ST_EMPTY;
         end else if (c == CMD_POP_HEAD) begin
            r.removed = take_at(0);
         end else if (c == CMD_POP_TAIL) begin
            r.removed = take_at(fill - 1);
         end else begin
            hit = 1'b0;
            for (i = 0; i < fill; i++) begin
               if (held[i] == v) begin
                  hit = 1'b1;
                  break;
               end
            end
            if (hit) r.removed = take_at(i);
            else r.status = ST_NOT_FOUND;
         end
         r.count = fill[COUNT_OUT_BITS-1:0];
         awaited.push_back(r);
      endfunction

      function void check_reply(logic [STATUS_BITS-1:0] st, logic [VALUE_BITS-1:0] rv,
                                logic [COUNT_OUT_BITS-1:0] cnt);
         reply_type e;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected word: status %0d removed %0d count %0d",
                     $time, st, $signed(rv), cnt);
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (st !== e.status || rv !== e.removed || cnt !== e.count) begin
            $display("%0t: mismatch: expected status %0d removed %0d count %0d,",
                     $time, e.status, $signed(e.removed), e.count,
                     " got status %0d removed %0d count %0d",
                     st, $signed(rv), cnt);
            errors++;
         end
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      function logic signed [VALUE_BITS-1:0] pick_held();
         return held[$urandom_range(0, fill - 1)];
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [CMD_BITS-1:0] req_tuser = '0;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [STATUS_BITS-1:0] rsp_tuser;
   logic [RSP_BITS-1:0] rsp_tdata;

   list_scoreboard sb = new();
   bit steady = 1'b0;
   int unsigned idle_cycles = 0;

   sorted_priority_list #(
      .DEPTH(DEPTH),
      .VALUE_BITS(VALUE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_command(cmd_type'(req_tuser), req_tdata[VALUE_BITS-1:0]);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_reply(rsp_tuser, rsp_tdata[VALUE_BITS-1:0],
                        rsp_tdata[VALUE_BITS+COUNT_OUT_BITS-1:VALUE_BITS]);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("simulation failed");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4) return $signed($urandom_range(0, 8)) - 4;
      if (r == 4) begin
         case ($urandom_range(0, 3))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   initial begin
      int unsigned gap;
      do @(posedge clock); while (reset);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic send_command(cmd_type c, logic signed [VALUE_BITS-1:0] v);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= REQ_BITS'(v);
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_for_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic random_command(int unsigned insert_weight);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < insert_weight) begin
         send_command(CMD_INSERT, pick_value());
      end else begin
         case ($urandom_range(0, 2))
            0: send_command(CMD_POP_HEAD, $urandom);
            1: send_command(CMD_POP_TAIL, $urandom);
            default: begin
               if (sb.fill > 0 && $urandom_range(0, 3) != 0)
                  send_command(CMD_REMOVE, sb.pick_held());
               else
                  send_command(CMD_REMOVE, pick_value());
            end
         endcase
      end
   endtask

   initial begin
      int unsigned sent, span, weight;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty list, ties at the head and inside, duplicates, absent value
      send_command(CMD_POP_HEAD, 32'sd9);
      send_command(CMD_POP_TAIL, 32'sd9);
      send_command(CMD_REMOVE, 32'sd5);
      send_command(CMD_INSERT, 32'sd5);
      send_command(CMD_INSERT, 32'sd5);
      send_command(CMD_INSERT, VAL_MAX);
      send_command(CMD_INSERT, VAL_MAX);
      send_command(CMD_INSERT, VAL_MIN);
      send_command(CMD_INSERT, 32'sd5);
      send_command(CMD_INSERT, '0);
      send_command(CMD_INSERT, '1);
      send_command(CMD_REMOVE, 32'sd5);
      send_command(CMD_REMOVE, 32'sd7);
      send_command(CMD_REMOVE, VAL_MIN);
      send_command(CMD_POP_HEAD, '0);
      send_command(CMD_POP_TAIL, '1);
      wait_for_replies();

      // fill past full, then drain past empty
      repeat (DEPTH + 2) send_command(CMD_INSERT, pick_value());
      repeat (DEPTH / 2 + 1) begin
         send_command(CMD_POP_HEAD, $urandom);
         send_command(CMD_POP_TAIL, $urandom);
      end
      wait_for_replies();

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         span   = $urandom_range(20, 80);
         steady = ($urandom_range(0, 4) == 0);
         case ($urandom_range(0, 3))
            0: weight = 85;
            1: weight = 15;
            default: weight = 50;
         endcase
         repeat (span) random_command(weight);
         sent += span;
         if ($urandom_range(0, 5) == 0) wait_for_replies();
      end
      steady = 1'b0;

      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
